@@ hw/rtl/mpasd_pkg.sv @@
// Package for the microphone peak/average spike detector.
// Holds the fixed field widths and arithmetic constants; no dependencies.
`default_nettype none

package mpasd_pkg;

  // Fixed field and state widths
  localparam int unsigned DT_W      = 4;   // elapsed_ms
  localparam int unsigned MS_W      = 8;   // ms_counter and the log period
  localparam int unsigned SUM_W     = 15;  // peak_sum
  localparam int unsigned CNT_W     = 5;   // peak_count
  localparam int unsigned OUT_AVG_W = 10;  // average_level on the result
  localparam int unsigned OUT_W     = 1 + OUT_AVG_W + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  // Threshold terms: 2000*sample > avg*avg + 2120*avg
  localparam int unsigned SPIKE_SCALE_W = 11;
  localparam int unsigned THR_LIN_W     = 12;
  localparam logic [SPIKE_SCALE_W-1:0] SPIKE_SCALE = SPIKE_SCALE_W'(2000);
  localparam logic [THR_LIN_W-1:0]     THR_LIN     = THR_LIN_W'(2120);

  localparam logic [MS_W-1:0] MS_MAX       = '1;
  localparam logic [MS_W-1:0] PERIOD_RESET = MS_W'(10);

endpackage : mpasd_pkg

`default_nettype wire

@@ hw/rtl/mic_peak_average_spike_detect_top.sv @@
// Microphone spike detector with running average of logged peaks; needs mpasd_pkg.
// A result is registered and valid in the cycle after its sample transfer.
// Throughput: one sample per cycle unless m_axis_tready holds back a pending result;
// all work sits between the state registers and the output register, with the
// divide by the peak count done as a constant reciprocal multiply in the same cycle.
// Reset clears all state and the output; the log period resets to 10 ms.
`default_nettype none

module mic_peak_average_spike_detect_top
  import mpasd_pkg::*;
#(
  parameter int unsigned PEAKS_PER_AVERAGE = 30,
  parameter int unsigned SAMPLE_BITS       = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // configuration: log period in ms
  input  wire logic                   cfg_we_i,
  input  wire logic [MS_W-1:0]        cfg_wdata_i,
  // sample stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata: sample, elapsed_ms (zero padded)
  input  wire logic [((SAMPLE_BITS + DT_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  // result stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata: spike, average_level, average_updated (zero padded)
  output logic [OUT_TDATA_W-1:0]      m_axis_tdata
);

  localparam int unsigned RECIP_SHIFT = SUM_W + CNT_W;
  localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SHIFT) + PEAKS_PER_AVERAGE - 1) / PEAKS_PER_AVERAGE);
  localparam int unsigned PROD_W = SUM_W + RECIP_W;
  localparam int unsigned CMP_W  =
    ((SAMPLE_BITS > 12) ? 2 * SAMPLE_BITS : SAMPLE_BITS + 12) + 1;
  localparam logic [CNT_W-1:0] CNT_TARGET = CNT_W'(PEAKS_PER_AVERAGE);

  // state
  logic [MS_W-1:0]        period_q;
  logic [SAMPLE_BITS-1:0] peak_q, peak_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic [MS_W-1:0]        ms_q, ms_d;
  logic [SAMPLE_BITS-1:0] avg_q, avg_d;
  logic                   out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  // datapath
  logic                   fire;
  logic [SAMPLE_BITS-1:0] sample;
  logic [DT_W-1:0]        dt;
  logic [CMP_W-1:0]       lhs, rhs;
  logic                   spike;
  logic [SAMPLE_BITS-1:0] peak_new;
  logic [MS_W:0]          ms_sum;
  logic [MS_W-1:0]        ms_new;
  logic                   log_now;
  logic [SUM_W-1:0]       sum_new;
  logic [CNT_W-1:0]       cnt_new;
  logic [PROD_W-1:0]      prod;
  logic                   upd;

  assign fire          = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  assign sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign dt     = s_axis_tdata[SAMPLE_BITS +: DT_W];

  assign lhs   = CMP_W'(SPIKE_SCALE) * CMP_W'(sample);
  assign rhs   = CMP_W'(avg_q) * CMP_W'(avg_q) + CMP_W'(THR_LIN) * CMP_W'(avg_q);
  assign spike = lhs > rhs;

  assign peak_new = (sample > peak_q) ? sample : peak_q;
  assign ms_sum   = {1'b0, ms_q} + (MS_W + 1)'(dt);
  assign ms_new   = ms_sum[MS_W] ? MS_MAX : ms_sum[MS_W-1:0];
  assign log_now  = ms_new >= period_q;
  assign sum_new  = sum_q + SUM_W'(peak_new);
  assign cnt_new  = cnt_q + CNT_W'(1);
  // exact divide by the peak count for any 15-bit sum
  assign prod     = PROD_W'(sum_new) * PROD_W'(RECIP);
  assign upd      = log_now && (cnt_new == CNT_TARGET);

  always_comb begin
    peak_d = peak_new;
    ms_d   = ms_new;
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    avg_d  = avg_q;
    if (log_now) begin
      peak_d = '0;
      ms_d   = '0;
      sum_d  = sum_new;
      cnt_d  = cnt_new;
      if (upd) begin
        avg_d = prod[RECIP_SHIFT +: SAMPLE_BITS];
        sum_d = '0;
        cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PERIOD_RESET;
    end else if (cfg_we_i) begin
      period_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peak_q <= '0;
      sum_q  <= '0;
      cnt_q  <= '0;
      ms_q   <= '0;
      avg_q  <= '0;
    end else if (fire) begin
      peak_q <= peak_d;
      sum_q  <= sum_d;
      cnt_q  <= cnt_d;
      ms_q   <= ms_d;
      avg_q  <= avg_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
      out_data_q  <= OUT_TDATA_W'({upd, OUT_AVG_W'(avg_d), spike});
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // The peak count never reaches its target while stored.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q < CNT_TARGET)
    else $error("peak count reached target without averaging");

  // A new average clears all accumulation state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && upd) |=> (cnt_q == '0 && sum_q == '0 && peak_q == '0 && ms_q == '0))
    else $error("accumulators not cleared after average update");

  // The average only moves on an update transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !upd) |=> (avg_q == $past(avg_q)))
    else $error("average changed without update");

endmodule : mic_peak_average_spike_detect_top

`default_nettype wire

@@ bench/mpasd_checker.sv @@
// Checker for the microphone peak/average spike detector: watches the config
// port and both streams, predicts every result and compares it field by field.
// Depends on mpasd_pkg.
`default_nettype none

module mpasd_checker
  import mpasd_pkg::*;
#(
  parameter int unsigned PEAKS_PER_AVERAGE = 30,
  parameter int unsigned SAMPLE_BITS       = 10
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [MS_W-1:0]        cfg_wdata_i,
  input  wire logic                   s_axis_tvalid,
  input  wire logic                   s_axis_tready,
  // tdata: sample, elapsed_ms (zero padded)
  input  wire logic [((SAMPLE_BITS + DT_W + 7) / 8) * 8 - 1:0] s_axis_tdata,
  input  wire logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // tdata: spike, average_level, average_updated (zero padded)
  input  wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output int                          mismatches_o,
  output int                          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SPIKE_GAIN  = 2000;
  localparam int unsigned LINEAR_GAIN = 2120;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic                 spike;
    logic [OUT_AVG_W-1:0] level;
    logic                 updated;
  } detect_result_t;

  detect_result_t expected_results[$];
  int             mismatch_count;
  int             result_index;

  logic [SAMPLE_BITS-1:0] peak_q;
  logic [SUM_W-1:0]       peak_sum_q;
  logic [CNT_W-1:0]       peak_count_q;
  logic [MS_W-1:0]        ms_q;
  logic [SAMPLE_BITS-1:0] average_q;
  logic [MS_W-1:0]        log_period_q;

  // Advance the detector by one sample and return the result it produces.
  task automatic detect_step(input logic [SAMPLE_BITS-1:0] smp, input logic [DT_W-1:0] dt,
                             output detect_result_t res);
    logic [31:0] level_term;
    logic [31:0] threshold;
    logic [MS_W:0] ms_sum;
    level_term = SPIKE_GAIN * 32'(smp);
    threshold  = 32'(average_q) * 32'(average_q) + LINEAR_GAIN * 32'(average_q);
    res.spike   = level_term > threshold;
    res.updated = 1'b0;
    if (smp > peak_q) begin
      peak_q = smp;
    end
    ms_sum = {1'b0, ms_q} + (MS_W + 1)'(dt);
    ms_q   = (ms_sum > {1'b0, MS_MAX}) ? MS_MAX : ms_sum[MS_W-1:0];
    if (ms_q >= log_period_q) begin
      peak_sum_q   = peak_sum_q + SUM_W'(peak_q);
      peak_q       = '0;
      peak_count_q = peak_count_q + 1'b1;
      ms_q         = '0;
      if (peak_count_q >= CNT_W'(PEAKS_PER_AVERAGE) && peak_count_q != '0) begin
        average_q    = SAMPLE_BITS'(peak_sum_q / peak_count_q);
        peak_sum_q   = '0;
        peak_count_q = '0;
        res.updated  = 1'b1;
      end
    end
    res.level = OUT_AVG_W'(average_q);
  endtask

  task automatic note_mismatch(input string field, input int want, input int got);
    if (mismatch_count < MAX_REPORTS) begin
      $display("[%0t] result %0d: %s expected %0d, got %0d", $realtime, result_index, field,
               want, got);
    end
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    detect_result_t want;
    detect_result_t got;
    if (!rst_ni) begin
      expected_results.delete();
      mismatch_count = 0;
      result_index   = 0;
      peak_q         = '0;
      peak_sum_q     = '0;
      peak_count_q   = '0;
      ms_q           = '0;
      average_q      = '0;
      log_period_q   = PERIOD_RESET;
      mismatches_o  <= 0;
      pending_o     <= 0;
    end else begin
      if (cfg_we_i) begin
        log_period_q = cfg_wdata_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        detect_step(s_axis_tdata[SAMPLE_BITS-1:0], s_axis_tdata[SAMPLE_BITS +: DT_W], want);
        expected_results.push_back(want);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.spike   = m_axis_tdata[0];
        got.level   = m_axis_tdata[1 +: OUT_AVG_W];
        got.updated = m_axis_tdata[OUT_AVG_W + 1];
        if (expected_results.size() == 0) begin
          if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] result %0d arrived with nothing expected", $realtime,
                     result_index);
          end
          mismatch_count++;
        end else begin
          want = expected_results.pop_front();
          if (got.spike !== want.spike) note_mismatch("spike", want.spike, got.spike);
          if (got.level !== want.level) note_mismatch("average_level", want.level, got.level);
          if (got.updated !== want.updated) begin
            note_mismatch("average_updated", want.updated, got.updated);
          end
        end
        result_index++;
      end
      mismatches_o <= mismatch_count;
      pending_o    <= expected_results.size();
    end
  end

endmodule : mpasd_checker

`default_nettype wire

@@ bench/testbench.sv @@
// Top of the spike detector bench: clock, reset, sample stimulus, config writes
// and the verdict. Depends on mpasd_pkg, mpasd_checker and the detector RTL.
`default_nettype none

module testbench
  import mpasd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PEAKS_PER_AVERAGE = 30;
  localparam int unsigned SAMPLE_BITS       = 10;
  localparam int unsigned IN_TDATA_W        = ((SAMPLE_BITS + DT_W + 7) / 8) * 8;
  localparam int unsigned WATCHDOG_LIMIT    = 1000;
  localparam int unsigned DIRECTED_ITEMS    = 20;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   cfg_we_i      = 1'b0;
  logic [MS_W-1:0]        cfg_wdata_i   = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   calm          = 1'b0;
  int                     mismatches;
  int                     pending;
  int                     quiet_cycles  = 0;

  // Hand-picked samples and gaps run against the reset period of 10 ms.
  int dir_sample [DIRECTED_ITEMS] = '{0, 1, 1023, 0, 512, 341, 682, 1023, 0, 1,
                                      1023, 1022, 0, 85, 170, 1023, 0, 512, 7, 1000};
  int dir_dt     [DIRECTED_ITEMS] = '{0, 0, 0, 15, 5, 4, 1, 15, 8, 2,
                                      9, 1, 0, 15, 15, 15, 15, 10, 3, 6};

  always #5 clk_i = ~clk_i;

  mic_peak_average_spike_detect_top #(
    .PEAKS_PER_AVERAGE(PEAKS_PER_AVERAGE),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  mpasd_checker #(
    .PEAKS_PER_AVERAGE(PEAKS_PER_AVERAGE),
    .SAMPLE_BITS      (SAMPLE_BITS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // Result sink: stall about one cycle in five unless in the calm stretch.
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 20);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Mostly quiet background with loud bursts, plus some full-range noise.
  function automatic logic [SAMPLE_BITS-1:0] draw_sample(input int loud);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return SAMPLE_BITS'($urandom_range(0, loud));
    if (pick < 85) return SAMPLE_BITS'($urandom_range(loud, (1 << SAMPLE_BITS) - 1));
    return SAMPLE_BITS'($urandom());
  endfunction

  // Keep tvalid high across back-to-back transfers; lower it only to idle.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] smp, input logic [DT_W-1:0] dt);
    if (!calm && $urandom_range(0, 99) < 20) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({dt, smp});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic run_period(input logic [MS_W-1:0] period, input int n_items, input int loud);
    drain_results();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= period;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    for (int i = 0; i < n_items; i++) begin
      send_sample(draw_sample(loud), DT_W'($urandom_range(0, 15)));
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ITEMS; i++) begin
      send_sample(SAMPLE_BITS'(dir_sample[i]), DT_W'(dir_dt[i]));
    end
    for (int i = 0; i < 200; i++) begin
      send_sample(draw_sample(300), DT_W'($urandom_range(0, 15)));
    end

    calm <= 1'b1;
    run_period(MS_W'(1), 200, 200);
    calm <= 1'b0;
    // longest period: the ms counter saturates on its way up
    run_period(MS_MAX, 120, 600);
    // zero period logs a peak on every sample
    run_period('0, 150, 400);
    run_period(MS_W'($urandom_range(2, 60)), 150, 500);
    run_period(MS_W'(2), 150, 100);

    drain_results();
    repeat (4) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : testbench

`default_nettype wire

@@ sim.f @@
hw/rtl/mpasd_pkg.sv
hw/rtl/mic_peak_average_spike_detect_top.sv
bench/mpasd_checker.sv
bench/testbench.sv
